>>> sv/greedy_word_wrap_core_macros.svh
// ----------------------------------------------------------------------------
// Greedy word wrap assertion macros
// Shared assertion shorthands for the greedy word wrap checker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_CORE_MACROS_SVH
`define GREEDY_WORD_WRAP_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GWW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define GWW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// Types and constants shared by the greedy word wrap core and its checker.
// ----------------------------------------------------------------------------
package gww_pkg;

	localparam int CP_W     = 21;
	localparam int LW_W     = 8;
	localparam int MAX_WORD = 32;
	localparam int WL_W     = $clog2(MAX_WORD + 1);
	localparam int WA_W     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	localparam logic [CP_W-1:0] CH_NL = CP_W'(10);
	localparam logic [CP_W-1:0] CH_SP = CP_W'(32);

	localparam logic [LW_W-1:0] LW_RESET = LW_W'(80);

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            text_end;
	} item_t;

	typedef struct packed {
		logic [CP_W-1:0] out_char;
		logic            run_last;
		logic            word_overflow;
	} res_t;

endpackage

>>> sv/greedy_word_wrap_core.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_core
// Reflows code points into lines of at most line_width columns or one word.
// ----------------------------------------------------------------------------
//
// Channel  Handshake             Beat
// -------  --------------------  -------------------------------------------
// item     item_valid/item_stall gww_pkg::item_t  (code_point, text_end)
// res      res_valid/res_stall   gww_pkg::res_t   (out_char, run_last, ovf)
// cfg      cfg_valid/cfg_ready   cfg_data = line_width
//
// After accepting an item, the sequencer emits its result beats (gap, each
// buffered word character, trailing/paragraph newlines) one beat per cycle
// while res is not stalled; the word store read port sets that pace.
// Items that produce no beat (mid-text word characters) are taken every cycle.
// arst_n clears all control state; the word store itself is not cleared.
// A stall on res only pauses the sequencer; item_stall stays high meanwhile.
//
module greedy_word_wrap_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  gww_pkg::item_t         item,
	output logic                   res_valid,
	input  logic                   res_stall,
	output gww_pkg::res_t          res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [gww_pkg::LW_W-1:0] cfg_data
);
	import gww_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GAP  = 2'd1;
	localparam logic [1:0] ST_WORD = 2'd2;
	localparam logic [1:0] ST_TAIL = 2'd3;

	// newline run codes
	localparam logic [1:0] RUN_NONE = 2'd0;
	localparam logic [1:0] RUN_ONE  = 2'd1;
	localparam logic [1:0] RUN_PARA = 2'd2;

	// ---- architectural text state ----
	logic [LW_W-1:0] lw_q;     // line_width register
	logic [WL_W-1:0] wl_q;     // buffered word length
	logic [LW_W-1:0] ll_q;     // current line length
	logic            gap_q;    // soft gap pending
	logic [1:0]      run_q;    // newline run, saturates at two
	logic            para_q;   // at paragraph start
	logic            trunc_q;  // word lost characters

	// ---- sequencer ----
	logic [1:0]      st_q;
	logic [WL_W-1:0] idx_q;    // word character being shown
	logic [WL_W-1:0] len_q;    // word length of this flush
	logic [1:0]      tail_q;   // trailing separator beats left
	logic            tail_sp_q;
	logic            gap_sp_q;
	logic            ovf_q;

	// ---- word store: one write, one registered read ----
	logic [CP_W-1:0] mem [MAX_WORD];
	logic [CP_W-1:0] rdata_q;
	logic            we;
	logic [WA_W-1:0] wa;
	logic            re;
	logic [WA_W-1:0] ra;

	// ---- output register ----
	logic  res_valid_q;
	res_t  res_q;
	logic  can_load;
	logic  ld;
	res_t  beat;

	// ---- accept-time decode ----
	logic            acc;
	logic            is_nl, is_sp, is_word, store, flush, gap, fits;
	logic [WL_W-1:0] wl_new;
	logic            trunc_new;
	logic [LW_W:0]   sum_sp, sum_ng;
	logic [1:0]      tail_n;

	logic [WL_W-1:0] wl_n;
	logic [LW_W-1:0] ll_n;
	logic            gap_n, para_n, trunc_n;
	logic [1:0]      run_n;

	logic [1:0]      st_n;
	logic [WL_W-1:0] idx_n;
	logic [WL_W-1:0] idx_inc;
	logic [1:0]      tail_cnt_n;
	logic            word_done;

	function automatic logic [LW_W-1:0] sat_ll(input logic [LW_W:0] v);
		sat_ll = v[LW_W] ? {LW_W{1'b1}} : v[LW_W-1:0];
	endfunction

	assign item_stall = (st_q != ST_IDLE);
	assign acc        = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign can_load   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// text state update for the accepted item
	always_comb begin
		is_nl     = (item.code_point == CH_NL);
		is_sp     = (item.code_point == CH_SP);
		is_word   = !is_nl && !is_sp;
		store     = is_word && (wl_q < WL_W'(MAX_WORD));
		wl_new    = wl_q + WL_W'(store);
		trunc_new = trunc_q | (is_word & ~store);
		flush     = (is_nl || is_sp || item.text_end) && (wl_new != '0);
		gap       = flush && !para_q && gap_q;
		sum_sp    = (LW_W+1)'(ll_q) + (LW_W+1)'(1) + (LW_W+1)'(wl_new);
		sum_ng    = (LW_W+1)'(ll_q) + (LW_W+1)'(wl_new);
		fits      = sum_sp <= (LW_W+1)'(lw_q);

		wl_n    = wl_new;
		ll_n    = ll_q;
		gap_n   = gap_q;
		para_n  = para_q;
		trunc_n = trunc_new;
		run_n   = run_q;
		tail_n  = 2'd0;

		if (flush) begin
			if (gap) begin
				ll_n = fits ? sat_ll(sum_sp) : sat_ll((LW_W+1)'(wl_new));
			end else begin
				ll_n = sat_ll(sum_ng);
			end
			wl_n    = '0;
			trunc_n = 1'b0;
			para_n  = 1'b0;
			gap_n   = 1'b0;
		end

		if (is_nl) begin
			unique case (run_q)
				RUN_NONE: begin
					run_n  = RUN_ONE;
					gap_n  = 1'b1;
					tail_n = {1'b0, item.text_end};
				end
				RUN_ONE: begin
					run_n  = RUN_PARA;
					gap_n  = 1'b0;
					ll_n   = '0;
					para_n = 1'b1;
					tail_n = 2'd2;
				end
				default: begin
					tail_n = 2'd1;
				end
			endcase
		end else if (is_sp) begin
			run_n  = RUN_NONE;
			gap_n  = 1'b1;
			tail_n = {1'b0, item.text_end};
		end else begin
			run_n = RUN_NONE;
		end

		// end of text: back to a fresh text
		if (item.text_end) begin
			wl_n    = '0;
			ll_n    = '0;
			gap_n   = 1'b0;
			run_n   = RUN_NONE;
			para_n  = 1'b1;
			trunc_n = 1'b0;
		end
	end

	// beat sequencer
	always_comb begin
		st_n       = st_q;
		idx_n      = idx_q;
		tail_cnt_n = tail_q;
		ld         = 1'b0;
		beat       = '0;
		idx_inc    = idx_q + WL_W'(1);
		word_done  = (idx_inc == len_q);
		we         = acc && store;
		wa         = wl_q[WA_W-1:0];
		re         = acc;          // prefetch first character
		ra         = '0;

		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					idx_n      = '0;
					tail_cnt_n = tail_n;
					if (gap) begin
						st_n = ST_GAP;
					end else if (flush) begin
						st_n = ST_WORD;
					end else if (tail_n != 2'd0) begin
						st_n = ST_TAIL;
					end
				end
			end
			ST_GAP: begin
				if (can_load) begin
					ld                 = 1'b1;
					beat.out_char      = gap_sp_q ? CH_SP : CH_NL;
					beat.word_overflow = ovf_q;
					st_n               = ST_WORD;
				end
			end
			ST_WORD: begin
				if (can_load) begin
					ld                 = 1'b1;
					beat.out_char      = rdata_q;
					beat.run_last      = word_done && (tail_q == 2'd0);
					beat.word_overflow = ovf_q;
					idx_n              = idx_inc;
					re                 = !word_done;
					ra                 = idx_inc[WA_W-1:0];
					if (word_done) begin
						st_n = (tail_q != 2'd0) ? ST_TAIL : ST_IDLE;
					end
				end
			end
			default: begin
				if (can_load) begin
					ld            = 1'b1;
					beat.out_char = tail_sp_q ? CH_SP : CH_NL;
					beat.run_last = (tail_q == 2'd1);
					tail_cnt_n    = tail_q - 2'd1;
					if (tail_q == 2'd1) begin
						st_n = ST_IDLE;
					end
				end
			end
		endcase
	end

	// word store, read data forwarded when the same entry is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= item.code_point;
		end
		if (re) begin
			if (we && (wa == ra)) begin
				rdata_q <= item.code_point;
			end else begin
				rdata_q <= mem[ra];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q        <= LW_RESET;
			wl_q        <= '0;
			ll_q        <= '0;
			gap_q       <= 1'b0;
			run_q       <= RUN_NONE;
			para_q      <= 1'b1;
			trunc_q     <= 1'b0;
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			len_q       <= '0;
			tail_q      <= 2'd0;
			tail_sp_q   <= 1'b0;
			gap_sp_q    <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lw_q <= cfg_data;
			end
			if (acc) begin
				wl_q      <= wl_n;
				ll_q      <= ll_n;
				gap_q     <= gap_n;
				run_q     <= run_n;
				para_q    <= para_n;
				trunc_q   <= trunc_n;
				len_q     <= wl_new;
				tail_sp_q <= is_sp;
				gap_sp_q  <= fits;
				ovf_q     <= trunc_new;
			end
			st_q   <= st_n;
			idx_q  <= idx_n;
			tail_q <= tail_cnt_n;
			if (ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ld) begin
			res_q <= beat;
		end
	end

endmodule

>>> sv/gww_checker.sv
// ----------------------------------------------------------------------------
// gww_checker
// Port-level checks for the greedy word wrap core, bound into the core module.
// ----------------------------------------------------------------------------
`include "greedy_word_wrap_core_macros.svh"

module gww_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input gww_pkg::item_t           item,
	input logic                     res_valid,
	input logic                     res_stall,
	input gww_pkg::res_t            res,
	input logic                     cfg_valid,
	input logic                     cfg_ready
);
	import gww_pkg::*;

	logic item_acc;
	logic word_char;

	assign item_acc  = item_valid && !item_stall;
	assign word_char = (item.code_point != CH_NL) && (item.code_point != CH_SP);

	// a stalled result beat holds
	`GWW_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result beat changed under stall")

	// leaving busy means the item's last beat was just loaded
	`GWW_ASSERT_IMP(a_busy_end, clk, arst_n, $fell(item_stall), res_valid && res.run_last, "busy dropped without a last beat")

	// a plain word character produces nothing and keeps the block ready
	`GWW_ASSERT_NXT(a_word_ready, clk, arst_n, item_acc && word_char && !item.text_end, !item_stall, "stalled after a buffered character")

	// a final space always emits at least the trailing space
	`GWW_ASSERT_NXT(a_end_space, clk, arst_n, item_acc && item.text_end && (item.code_point == CH_SP), item_stall, "final space produced no beat")

	// configuration port is always open
	`GWW_ASSERT_IMP(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind greedy_word_wrap_core gww_checker u_gww_checker (.*);
